// ===== rtl/sasp_pkg.sv =====
// ----------------------------------------------------------------------------
// sasp_pkg: shared types, constants and helpers for the sky projection core
// Fixed-point formats, angle constants in Q30, series divisors, register codes.
// ----------------------------------------------------------------------------
package sasp_pkg;

	localparam int ANGLE_FRACTION_BITS    = 13;
	localparam int POSITION_FRACTION_BITS = 4;
	localparam int Q_FRAC                 = 30;
	localparam int ANG_SHIFT              = Q_FRAC - ANGLE_FRACTION_BITS;

	localparam int ANG_W = 36;
	localparam int Q_W   = 34;
	localparam int NUM_W = 52;
	localparam int POS_W = 20;
	localparam int CFG_W = 15;
	localparam int IDX_W = 2;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [Q_W-1:0]   q_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic signed [POS_W-1:0] pos_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FOV,
		REG_CAM_EL,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	localparam logic [14:0]        RST_FOV    = 15'd8578;
	localparam logic signed [14:0] RST_CAM_EL = 15'sd0;
	localparam logic [13:0]        RST_WIDTH  = 14'd1920;
	localparam logic [13:0]        RST_HEIGHT = 14'd1080;

	localparam ang_t PI_Q          = 36'sd3373259426;
	localparam ang_t NEG_PI_Q      = -36'sd3373259426;
	localparam ang_t TWO_PI_Q      = 36'sd6746518852;
	localparam ang_t HALF_PI_Q     = 36'sd1686629713;
	localparam ang_t NEG_HALF_PI_Q = -36'sd1686629713;

	localparam pos_t POS_MAX = 20'h7FFFF;
	localparam pos_t POS_MIN = 20'h80000;

	// series: term n is the previous one times x^2 over (2n)(2n+1)
	localparam int TAYLOR_TERMS = 7;
	localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};
	localparam int unsigned TAYLOR_SH  [1:7] = '{3, 5, 6, 7, 7, 8, 8};

	localparam int SIN_LAT = 3 + 2 * TAYLOR_TERMS + 1;
	localparam int DIV_LAT = POS_W + 3;

	// sign-magnitude Q30 product, magnitude truncated
	function automatic q_t qmul(input q_t a, input q_t b);
		logic [Q_W-1:0]   ma;
		logic [Q_W-1:0]   mb;
		logic [Q_W-1:0]   r;
		logic [2*Q_W-1:0] p;
		ma = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
		mb = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
		p  = (2*Q_W)'(ma) * (2*Q_W)'(mb);
		r  = p[Q_FRAC+Q_W-1:Q_FRAC];
		return (a[Q_W-1] ^ b[Q_W-1]) ? -q_t'(r) : q_t'(r);
	endfunction

endpackage

// ===== rtl/sasp_sine.sv =====
// ----------------------------------------------------------------------------
// sasp_sine: pipelined Q30 sine
// Range reduction, fold, then one multiply and one reciprocal divide per term.
// ----------------------------------------------------------------------------
module sasp_sine (
	input  logic            clk,
	input  logic            en,
	input  sasp_pkg::ang_t  angle,
	output sasp_pkg::q_t    sine
);

	localparam int NT = sasp_pkg::TAYLOR_TERMS;

	sasp_pkg::ang_t xr_s1;
	logic           neg_s2;
	logic [31:0]    m0_s2;
	logic           neg_s3;
	logic [31:0]    m0_s3;
	logic [31:0]    x2_s3;
	logic [63:0]    sq;

	logic [31:0]    p_a   [1:NT];
	logic [31:0]    x2_a  [1:NT];
	logic           neg_a [1:NT];
	sasp_pkg::q_t   sum_a [1:NT];
	logic [31:0]    m_b   [1:NT];
	logic [31:0]    x2_b  [1:NT];
	logic           neg_b [1:NT];
	sasp_pkg::q_t   sum_b [1:NT];

	assign sq = 64'(m0_s2) * 64'(m0_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			// wrap into [-pi, pi]
			if (angle > sasp_pkg::PI_Q)
				xr_s1 <= angle - sasp_pkg::TWO_PI_Q;
			else if (angle < sasp_pkg::NEG_PI_Q)
				xr_s1 <= angle + sasp_pkg::TWO_PI_Q;
			else
				xr_s1 <= angle;
			// fold into [-pi/2, pi/2], keep sign and magnitude
			if (xr_s1 > sasp_pkg::HALF_PI_Q) begin
				neg_s2 <= 1'b0;
				m0_s2  <= 32'(sasp_pkg::PI_Q - xr_s1);
			end else if (xr_s1 < sasp_pkg::NEG_HALF_PI_Q) begin
				neg_s2 <= 1'b1;
				m0_s2  <= 32'(sasp_pkg::PI_Q + xr_s1);
			end else begin
				neg_s2 <= xr_s1[sasp_pkg::ANG_W-1];
				m0_s2  <= xr_s1[sasp_pkg::ANG_W-1] ? 32'(-xr_s1) : 32'(xr_s1);
			end
			neg_s3 <= neg_s2;
			m0_s3  <= m0_s2;
			x2_s3  <= sq[61:30];
		end
	end

	for (genvar n = 1; n <= NT; n++) begin : g_term
		localparam int unsigned DV = sasp_pkg::TAYLOR_DIV[n];
		localparam int unsigned SH = sasp_pkg::TAYLOR_SH[n];
		localparam logic [32:0] RCP =
			33'(((65'd1 << (32 + SH)) + 65'(DV) - 65'd1) / 65'(DV));

		logic [31:0]  m_in;
		logic [31:0]  x2_in;
		logic         neg_in;
		sasp_pkg::q_t sum_in;
		logic [63:0]  pm;
		logic [64:0]  pq;

		if (n == 1) begin : g_head
			assign m_in   = m0_s3;
			assign x2_in  = x2_s3;
			assign neg_in = neg_s3;
			assign sum_in = sasp_pkg::q_t'(m0_s3);
		end else begin : g_body
			assign m_in   = m_b[n-1];
			assign x2_in  = x2_b[n-1];
			assign neg_in = neg_b[n-1];
			// fold the previous term into the running sum, alternating sign
			if ((n - 1) % 2 == 1) begin : g_sub
				assign sum_in = sum_b[n-1] - sasp_pkg::q_t'(m_b[n-1]);
			end else begin : g_add
				assign sum_in = sum_b[n-1] + sasp_pkg::q_t'(m_b[n-1]);
			end
		end

		assign pm = 64'(m_in) * 64'(x2_in);
		assign pq = 65'(p_a[n]) * 65'(RCP);

		always_ff @(posedge clk) begin
			if (en) begin
				p_a[n]   <= pm[61:30];
				x2_a[n]  <= x2_in;
				neg_a[n] <= neg_in;
				sum_a[n] <= sum_in;
				m_b[n]   <= 32'(pq >> (32 + SH));
				x2_b[n]  <= x2_a[n];
				neg_b[n] <= neg_a[n];
				sum_b[n] <= sum_a[n];
			end
		end
	end

	if (NT % 2 == 1) begin : g_last_sub
		always_ff @(posedge clk) begin
			if (en)
				sine <= neg_b[NT] ? sasp_pkg::q_t'(m_b[NT]) - sum_b[NT]
				                  : sum_b[NT] - sasp_pkg::q_t'(m_b[NT]);
		end
	end else begin : g_last_add
		always_ff @(posedge clk) begin
			if (en)
				sine <= neg_b[NT] ? -(sum_b[NT] + sasp_pkg::q_t'(m_b[NT]))
				                  : sum_b[NT] + sasp_pkg::q_t'(m_b[NT]);
		end
	end

endmodule

// ===== rtl/sasp_rdiv.sv =====
// ----------------------------------------------------------------------------
// sasp_rdiv: pipelined rounding divide with saturation
// Computes round(num / (2 den)), ties away from zero, one quotient bit a stage.
// ----------------------------------------------------------------------------
module sasp_rdiv (
	input  logic           clk,
	input  logic           en,
	input  sasp_pkg::num_t num,
	input  sasp_pkg::q_t   den,
	output sasp_pkg::pos_t quo
);

	localparam int QB = sasp_pkg::POS_W;
	localparam int RW = sasp_pkg::NUM_W + 2;

	logic [sasp_pkg::NUM_W-1:0] num_mag;
	logic [sasp_pkg::Q_W-1:0]   den_mag;

	logic [RW-1:0] a_s0;
	logic [RW-1:0] b_s0;
	logic          neg_s0;

	logic [RW-1:0] rem_k [0:QB];
	logic [RW-1:0] b_k   [0:QB];
	logic [QB-1:0] q_k   [0:QB];
	logic          neg_k [0:QB];
	logic          ovf_k [0:QB];

	assign num_mag = num[sasp_pkg::NUM_W-1] ? sasp_pkg::NUM_W'(-num) : sasp_pkg::NUM_W'(num);
	assign den_mag = den[sasp_pkg::Q_W-1] ? sasp_pkg::Q_W'(-den) : sasp_pkg::Q_W'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			// add half the divisor for rounding
			a_s0   <= RW'(num_mag) + RW'(den_mag);
			b_s0   <= RW'(den_mag) << 1;
			neg_s0 <= num[sasp_pkg::NUM_W-1] ^ den[sasp_pkg::Q_W-1];
			// quotient beyond the result range saturates
			ovf_k[0] <= a_s0 >= (b_s0 << QB);
			rem_k[0] <= a_s0;
			b_k[0]   <= b_s0;
			q_k[0]   <= '0;
			neg_k[0] <= neg_s0;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = b_k[k-1] << (QB - k);
		assign ge    = rem_k[k-1] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_k[k] <= ge ? rem_k[k-1] - trial : rem_k[k-1];
				q_k[k]   <= {q_k[k-1][QB-2:0], ge};
				b_k[k]   <= b_k[k-1];
				neg_k[k] <= neg_k[k-1];
				ovf_k[k] <= ovf_k[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_k[QB])
				quo <= neg_k[QB] ? sasp_pkg::POS_MIN : sasp_pkg::POS_MAX;
			else if (neg_k[QB])
				quo <= (q_k[QB] > (QB'(1) << (QB - 1))) ? sasp_pkg::POS_MIN
				                                         : sasp_pkg::pos_t'(-q_k[QB]);
			else
				quo <= q_k[QB][QB-1] ? sasp_pkg::POS_MAX : sasp_pkg::pos_t'(q_k[QB]);
		end
	end

endmodule

// ===== rtl/sky_angle_to_screen_projection_core.sv =====
// ----------------------------------------------------------------------------
// sky_angle_to_screen_projection_core: pinhole projection of sky directions
// Maps azimuth/elevation to screen position in 1/16 pixel with status flags.
// ----------------------------------------------------------------------------
// The core takes one direction beat per clock while no valid output beat is
// stalled and returns one position beat per direction, in order, through the
// input register, the 18-stage series sine units (eight of them run side by
// side: sine and cosine of elevation, azimuth, camera pitch and half field of
// view), six stages of products and sums, the 23-stage quotient pipeline
// (operand, overflow, one-per-quotient-bit and saturation stages) and the
// output register. A stall on a valid output beat freezes the whole pipeline
// and is passed straight back as in_stall, so no beat is lost or repeated.
// Register writes take effect for the next accepted beat; write them only
// while the core is drained.
module sky_angle_to_screen_projection_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// register write port
	input  logic                          cfg_wen,
	input  logic [sasp_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [sasp_pkg::CFG_W-1:0]    cfg_data,
	// direction channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            azimuth,
	input  logic signed [14:0]            elevation,
	// position channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output sasp_pkg::pos_t                screen_x,
	output sasp_pkg::pos_t                screen_y,
	output logic                          behind_camera,
	output logic                          degenerate
);

	// sine unit slots
	localparam int A_SE = 0;
	localparam int A_CE = 1;
	localparam int A_SA = 2;
	localparam int A_CA = 3;
	localparam int A_SC = 4;
	localparam int A_CC = 5;
	localparam int A_SF = 6;
	localparam int A_CF = 7;
	localparam int NA   = 8;

	localparam int SL = sasp_pkg::SIN_LAT;
	localparam int DL = sasp_pkg::DIV_LAT;

	// configuration
	logic [14:0]        fov_q;
	logic signed [14:0] cam_el_q;
	logic [13:0]        width_q;
	logic [13:0]        height_q;

	logic en;

	// input stage
	logic                 vld_s1;
	sasp_pkg::ang_t       ang_s1 [NA];
	logic [13:0]          h_s1;
	logic [13:0]          w_s1;

	// alignment with the sine units
	logic                 vsin_d [SL];
	logic [13:0]          hsin_d [SL];
	logic [13:0]          wsin_d [SL];
	sasp_pkg::q_t         sv     [NA];

	// product stages
	logic                 vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	sasp_pkg::q_t         ceca_s2, cs_s2, ss_s2, p_s2, cc_s2, sc_s2, sf_s2, cf_s2;
	logic                 sez_s2, sez_s3, sez_s4, sez_s5;
	logic [13:0]          h_s2, h_s3, h_s4, h_s5;
	logic [13:0]          w_s2, w_s3, w_s4, w_s5;
	sasp_pkg::q_t         cc2_s3, sc2_s3, pcf_s3, cs_s3, ss_s3, sf_s3, cf_s3;
	sasp_pkg::q_t         nn_s4, dd_s4, pcf_s4, sf_s4, cf_s4;
	sasp_pkg::q_t         den_s5, ncf_s5, pcf_s5;
	logic                 beh_s5, beh_s6, beh_s7;
	sasp_pkg::num_t       hp_s6, wd_s6, hd_s6, hn_s6;
	sasp_pkg::q_t         den_s6, den_s7;
	logic                 degen_s6, degen_s7;
	sasp_pkg::num_t       numx_s7, numy_s7;

	// alignment with the dividers
	logic                 vdiv_d   [DL];
	logic                 behdiv_d [DL];
	logic                 dgndiv_d [DL];
	sasp_pkg::pos_t       qx;
	sasp_pkg::pos_t       qy;

	// advance everything unless the output beat is held
	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	// register writes; unknown codes cannot occur with a two-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_q    <= sasp_pkg::RST_FOV;
			cam_el_q <= sasp_pkg::RST_CAM_EL;
			width_q  <= sasp_pkg::RST_WIDTH;
			height_q <= sasp_pkg::RST_HEIGHT;
		end else if (cfg_wen) begin
			case (sasp_pkg::reg_idx_t'(cfg_idx))
				sasp_pkg::REG_FOV:    fov_q    <= cfg_data;
				sasp_pkg::REG_CAM_EL: cam_el_q <= cfg_data;
				sasp_pkg::REG_WIDTH:  width_q  <= cfg_data[13:0];
				sasp_pkg::REG_HEIGHT: height_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vsin_d    <= '{default: 1'b0};
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vdiv_d    <= '{default: 1'b0};
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vsin_d[0] <= vld_s1;
			for (int i = 1; i < SL; i++)
				vsin_d[i] <= vsin_d[i-1];
			vld_s2    <= vsin_d[SL-1];
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vdiv_d[0] <= vld_s7;
			for (int i = 1; i < DL; i++)
				vdiv_d[i] <= vdiv_d[i-1];
			out_valid <= vdiv_d[DL-1];
		end
	end

	// input stage: widen every angle to Q30, cosine as sine of x + pi/2
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[A_SE] <= sasp_pkg::ang_t'(elevation) <<< sasp_pkg::ANG_SHIFT;
			ang_s1[A_CE] <= (sasp_pkg::ang_t'(elevation) <<< sasp_pkg::ANG_SHIFT)
			                + sasp_pkg::HALF_PI_Q;
			ang_s1[A_SA] <= sasp_pkg::ang_t'(azimuth) <<< sasp_pkg::ANG_SHIFT;
			ang_s1[A_CA] <= (sasp_pkg::ang_t'(azimuth) <<< sasp_pkg::ANG_SHIFT)
			                + sasp_pkg::HALF_PI_Q;
			ang_s1[A_SC] <= sasp_pkg::ang_t'(cam_el_q) <<< sasp_pkg::ANG_SHIFT;
			ang_s1[A_CC] <= (sasp_pkg::ang_t'(cam_el_q) <<< sasp_pkg::ANG_SHIFT)
			                + sasp_pkg::HALF_PI_Q;
			ang_s1[A_SF] <= (sasp_pkg::ang_t'(fov_q) <<< sasp_pkg::ANG_SHIFT) >>> 1;
			ang_s1[A_CF] <= ((sasp_pkg::ang_t'(fov_q) <<< sasp_pkg::ANG_SHIFT) >>> 1)
			                + sasp_pkg::HALF_PI_Q;
			h_s1 <= height_q;
			w_s1 <= width_q;
		end
	end

	for (genvar i = 0; i < NA; i++) begin : g_sine
		sasp_sine u_sine (
			.clk   (clk),
			.en    (en),
			.angle (ang_s1[i]),
			.sine  (sv[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsin_d[0] <= h_s1;
			wsin_d[0] <= w_s1;
			for (int i = 1; i < SL; i++) begin
				hsin_d[i] <= hsin_d[i-1];
				wsin_d[i] <= wsin_d[i-1];
			end
		end
	end

	// rotate the direction into the camera frame, then scale to pixels
	always_ff @(posedge clk) begin
		if (en) begin
			// cosE cosAz, pitch products, horizontal component
			ceca_s2 <= sasp_pkg::qmul(sv[A_CE], sv[A_CA]);
			cs_s2   <= sasp_pkg::qmul(sv[A_CC], sv[A_SE]);
			ss_s2   <= sasp_pkg::qmul(sv[A_SC], sv[A_SE]);
			p_s2    <= sasp_pkg::qmul(sv[A_CE], sv[A_SA]);
			cc_s2   <= sv[A_CC];
			sc_s2   <= sv[A_SC];
			sf_s2   <= sv[A_SF];
			cf_s2   <= sv[A_CF];
			sez_s2  <= sv[A_SE] == '0;
			h_s2    <= hsin_d[SL-1];
			w_s2    <= wsin_d[SL-1];

			cc2_s3 <= sasp_pkg::qmul(cc_s2, ceca_s2);
			sc2_s3 <= sasp_pkg::qmul(sc_s2, ceca_s2);
			pcf_s3 <= sasp_pkg::qmul(p_s2, cf_s2);
			cs_s3  <= cs_s2;
			ss_s3  <= ss_s2;
			sf_s3  <= sf_s2;
			cf_s3  <= cf_s2;
			sez_s3 <= sez_s2;
			h_s3   <= h_s2;
			w_s3   <= w_s2;

			// N and D
			nn_s4  <= cs_s3 - sc2_s3;
			dd_s4  <= cc2_s3 + ss_s3;
			pcf_s4 <= pcf_s3;
			sf_s4  <= sf_s3;
			cf_s4  <= cf_s3;
			sez_s4 <= sez_s3;
			h_s4   <= h_s3;
			w_s4   <= w_s3;

			den_s5 <= sasp_pkg::qmul(sf_s4, dd_s4);
			ncf_s5 <= sasp_pkg::qmul(nn_s4, cf_s4);
			beh_s5 <= dd_s4[sasp_pkg::Q_W-1];
			pcf_s5 <= pcf_s4;
			sez_s5 <= sez_s4;
			h_s5   <= h_s4;
			w_s5   <= w_s4;

			hp_s6    <= sasp_pkg::num_t'(h_s5) * sasp_pkg::num_t'(pcf_s5);
			wd_s6    <= sasp_pkg::num_t'(w_s5) * sasp_pkg::num_t'(den_s5);
			hd_s6    <= sasp_pkg::num_t'(h_s5) * sasp_pkg::num_t'(den_s5);
			hn_s6    <= sasp_pkg::num_t'(h_s5) * sasp_pkg::num_t'(ncf_s5);
			degen_s6 <= sez_s5 | (den_s5 == '0);
			beh_s6   <= beh_s5;
			den_s6   <= den_s5;

			// numerators in sub-pixel units
			numx_s7  <= (hp_s6 + wd_s6) <<< sasp_pkg::POSITION_FRACTION_BITS;
			numy_s7  <= (hd_s6 - hn_s6) <<< sasp_pkg::POSITION_FRACTION_BITS;
			den_s7   <= den_s6;
			degen_s7 <= degen_s6;
			beh_s7   <= beh_s6;
		end
	end

	sasp_rdiv u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s7),
		.den (den_s7),
		.quo (qx)
	);

	sasp_rdiv u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s7),
		.den (den_s7),
		.quo (qy)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			behdiv_d[0] <= beh_s7;
			dgndiv_d[0] <= degen_s7;
			for (int i = 1; i < DL; i++) begin
				behdiv_d[i] <= behdiv_d[i-1];
				dgndiv_d[i] <= dgndiv_d[i-1];
			end
		end
	end

	// output register: a degenerate beat (zero divisor or zero elevation sine) overrides the quotients
	always_ff @(posedge clk) begin
		if (en) begin
			degenerate    <= dgndiv_d[DL-1];
			behind_camera <= dgndiv_d[DL-1] ? 1'b0 : behdiv_d[DL-1];
			screen_x      <= dgndiv_d[DL-1] ? sasp_pkg::POS_MAX : qx;
			screen_y      <= dgndiv_d[DL-1] ? sasp_pkg::POS_MAX : qy;
		end
	end

endmodule

// ===== rtl/sasp_chk.sv =====
// ----------------------------------------------------------------------------
// sasp_chk: port-level checks for the sky projection core
// Back-pressure path, held output beats and the degenerate result encoding.
// ----------------------------------------------------------------------------
module sasp_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_stall,
	input  logic           out_valid,
	input  logic           out_stall,
	input  sasp_pkg::pos_t screen_x,
	input  sasp_pkg::pos_t screen_y,
	input  logic           behind_camera,
	input  logic           degenerate
);

	// input is held back exactly while an output beat is held
	a_stall_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow the held output beat");

	// a held output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(screen_y)
		&& $stable(degenerate) && $stable(behind_camera))
		else $error("held output beat changed");

	// degenerate beats carry saturated positions and no behind flag
	a_degen_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> !behind_camera
		&& screen_x == sasp_pkg::POS_MAX && screen_y == sasp_pkg::POS_MAX)
		else $error("degenerate beat with wrong encoding");

endmodule

bind sky_angle_to_screen_projection_core sasp_chk u_sasp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.screen_x      (screen_x),
	.screen_y      (screen_y),
	.behind_camera (behind_camera),
	.degenerate    (degenerate)
);
